>>> design/hsd_pkg.sv
`timescale 1ns / 1ps
// shared types and codes for the one-dimensional heat stencil block
package hsd_pkg;

  // field and register types
  typedef logic signed [23:0] val_t;
  typedef logic        [15:0] coef_t;
  typedef logic        [8:0]  gpts_t;
  typedef logic        [1:0]  kind_t;
  typedef logic        [1:0]  reg_idx_t;
  typedef logic        [7:0]  cidx_t;

  // input item kinds
  localparam kind_t KIND_STEP    = 2'd0;
  localparam kind_t KIND_READ    = 2'd1;
  localparam kind_t KIND_RESTART = 2'd2;

  // configuration register indexes
  localparam reg_idx_t REG_LEFT  = 2'd0;
  localparam reg_idx_t REG_RIGHT = 2'd1;
  localparam reg_idx_t REG_COEF  = 2'd2;
  localparam reg_idx_t REG_GPTS  = 2'd3;

  // register reset values
  localparam val_t  LEFT_RST  = 24'sd1048576;
  localparam val_t  RIGHT_RST = 24'sd2097152;
  localparam coef_t COEF_RST  = 16'd19661;
  localparam gpts_t GPTS_RST  = 9'd256;

  // Q4.20 saturation limits, on the widened update sum
  localparam logic signed [27:0] SUM_MAX = 28'sd8388607;
  localparam logic signed [27:0] SUM_MIN = -28'sd8388608;

  // rounding bias for the product with the Q0.16 coefficient
  localparam logic signed [42:0] RND_HALF = 43'sd32768;

endpackage

>>> design/hsd_ram.sv
`timescale 1ns / 1ps
// generic single write, single read memory with registered read data
module hsd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/hsd_update.sv
`timescale 1ns / 1ps
// shared stencil unit: laplacian, coefficient multiply, rounding and saturation
module hsd_update (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  hsd_pkg::val_t prev,
  input  hsd_pkg::val_t cur,
  input  hsd_pkg::val_t right,
  input  hsd_pkg::coef_t coef,
  output logic          res_vld,
  output hsd_pkg::val_t res,
  output logic          busy
);
  import hsd_pkg::*;

  logic                     s1_vld_r;
  logic                     s2_vld_r;
  logic                     s3_vld_r;
  logic signed [25:0]       lap_r;
  logic signed [25:0]       lap_nxt;
  val_t                     old1_r;
  val_t                     old2_r;
  logic signed [42:0]       prod_r;
  logic signed [42:0]       prod_nxt;
  logic signed [26:0]       delta;
  logic signed [27:0]       sum;
  val_t                     res_r;
  val_t                     res_nxt;
  logic signed [16:0]       coef_s;

  // stencil sum, exact in 26 bits
  always_comb begin
    lap_nxt = {{2{prev[23]}}, prev} + {{2{right[23]}}, right}
            - {{1{cur[23]}}, cur, 1'b0};
  end

  // coefficient as a positive signed operand
  assign coef_s   = {1'b0, coef};
  assign prod_nxt = 43'(lap_r * coef_s);

  // round half up, add old value, clamp to the Q4.20 range
  always_comb begin
    delta = 27'((prod_r + RND_HALF) >>> 16);
    sum   = {{4{old2_r[23]}}, old2_r} + {delta[26], delta};
    if (sum > SUM_MAX) begin
      res_nxt = SUM_MAX[23:0];
    end else if (sum < SUM_MIN) begin
      res_nxt = SUM_MIN[23:0];
    end else begin
      res_nxt = sum[23:0];
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  // stage data
  always_ff @(posedge clk) begin
    lap_r  <= lap_nxt;
    old1_r <= cur;
    prod_r <= prod_nxt;
    old2_r <= old1_r;
    res_r  <= res_nxt;
  end

  assign res_vld = s3_vld_r;
  assign res     = res_r;
  assign busy    = s1_vld_r | s2_vld_r | s3_vld_r;

endmodule

>>> design/heat_stencil_1d_step.sv
`timescale 1ns / 1ps
// top level of the one-dimensional explicit heat stencil block
//
// Input beats (in_valid/in_stall) carry a kind and a cell index: a step beat
// advances every interior cell by one explicit update, a restart beat zeroes
// the grid and loads the two boundary temperatures, a read beat returns one
// cell on the output channel (out_valid/out_stall); kind 3 is dropped.
// Only a read beat gives an output beat. Registers are written on cfg_we.
// A step walks the n cells in use once through one shared multiply-add
// unit, fed by one memory read a cycle, then drains. A restart does one
// memory write a cycle. An in-range read reads memory when taken; the read
// state loads the output register once that register is free. After reset a
// clearing pass zeroes the grid; in_stall is high meanwhile. The output
// register parts the channels: steps and restarts go on while out_stall
// is high; a held read beat stalls the next read, which keeps in_stall high.
module heat_stencil_1d_step #(
  parameter int GRID_MAX = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  hsd_pkg::kind_t    in_kind,
  input  hsd_pkg::cidx_t    in_cell_index,
  output logic              out_valid,
  input  logic              out_stall,
  output hsd_pkg::val_t     out_cell_value,
  output logic              out_index_error,
  input  logic              cfg_we,
  input  hsd_pkg::reg_idx_t cfg_index,
  input  logic [23:0]       cfg_wdata
);
  import hsd_pkg::*;

  localparam int AW = $clog2(GRID_MAX);
  localparam int NW = $clog2(GRID_MAX + 1);
  localparam int EW = (NW > 9) ? NW : 9;
  localparam logic [AW-1:0] LAST_ADDR = AW'(GRID_MAX - 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_STEP  = 5'b00100,
    S_DRAIN = 5'b01000,
    S_READ  = 5'b10000
  } state_t;

  state_t          state_r;
  state_t          state_nxt;
  val_t            left_r;
  val_t            right_r;
  coef_t           coef_r;
  gpts_t           gpts_r;
  logic            bnd_r;
  logic [AW-1:0]   cnt_r;
  logic [AW-1:0]   ra_r;
  logic [AW-1:0]   rd_a_r;
  logic            rv_r;
  logic [AW-1:0]   wa_r;
  val_t            w0_r;
  val_t            w1_r;
  logic            err_r;
  logic            out_valid_r;
  val_t            out_val_r;
  logic            out_err_r;
  logic [EW-1:0]   gp_ext;
  logic [EW-1:0]   n_ext;
  logic [NW-1:0]   n_m1;
  logic            idx_ok;
  logic            acc;
  logic            out_take;
  logic            out_free;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  val_t            ram_wdata;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  val_t            ram_rdata;
  logic            upd_start;
  logic            upd_vld;
  val_t            upd_res;
  logic            upd_busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r  <= LEFT_RST;
      right_r <= RIGHT_RST;
      coef_r  <= COEF_RST;
      gpts_r  <= GPTS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEFT:  left_r  <= cfg_wdata;
        REG_RIGHT: right_r <= cfg_wdata;
        REG_COEF:  coef_r  <= cfg_wdata[15:0];
        REG_GPTS:  gpts_r  <= cfg_wdata[8:0];
        default:   ;
      endcase
    end
  end

  // cells in use, clamped to 3..GRID_MAX
  always_comb begin
    gp_ext = EW'(gpts_r);
    if (gp_ext < EW'(3)) begin
      n_ext = EW'(3);
    end else if (gp_ext > EW'(GRID_MAX)) begin
      n_ext = EW'(GRID_MAX);
    end else begin
      n_ext = gp_ext;
    end
  end

  assign n_m1   = NW'(n_ext) - NW'(1);
  assign idx_ok = EW'(in_cell_index) < n_ext;

  // handshakes
  assign in_stall = (state_r != S_IDLE);
  assign acc      = in_valid & ~in_stall;
  assign out_take = out_valid_r & ~out_stall;
  assign out_free = ~out_valid_r | ~out_stall;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (cnt_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (acc) begin
          case (in_kind)
            KIND_STEP:    state_nxt = S_STEP;
            KIND_READ:    state_nxt = S_READ;
            KIND_RESTART: state_nxt = S_CLEAR;
            default:      state_nxt = S_IDLE;
          endcase
        end
      end
      S_STEP: begin
        if (NW'(ra_r) == n_m1) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rv_r && !upd_busy) begin
          state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      bnd_r   <= 1'b0;
      cnt_r   <= '0;
      ra_r    <= '0;
      wa_r    <= '0;
      rv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rv_r    <= (state_r == S_STEP);
      // sweep counter for clearing
      if (state_r == S_CLEAR) begin
        cnt_r <= (cnt_r == LAST_ADDR) ? '0 : cnt_r + AW'(1);
      end
      // launch of a step or restart
      if (acc && in_kind == KIND_STEP) begin
        ra_r <= '0;
        wa_r <= AW'(1);
      end else begin
        if (state_r == S_STEP) begin
          ra_r <= ra_r + AW'(1);
        end
        if (upd_vld) begin
          wa_r <= wa_r + AW'(1);
        end
      end
      if (acc && in_kind == KIND_RESTART) begin
        cnt_r <= '0;
        bnd_r <= 1'b1;
      end
    end
  end

  // read-data tags, stencil window and read error flag
  always_ff @(posedge clk) begin
    rd_a_r <= ra_r;
    if (rv_r) begin
      w0_r <= w1_r;
      w1_r <= ram_rdata;
    end
    if (acc) begin
      err_r <= ~idx_ok;
    end
  end

  // grid memory access
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_r;
    ram_wdata = '0;
    if (state_r == S_CLEAR) begin
      ram_we = 1'b1;
      if (bnd_r && cnt_r == '0) begin
        ram_wdata = left_r;
      end else if (bnd_r && NW'(cnt_r) == n_m1) begin
        ram_wdata = right_r;
      end
    end else if (upd_vld) begin
      ram_we    = 1'b1;
      ram_waddr = wa_r;
      ram_wdata = upd_res;
    end
  end

  assign ram_re    = (state_r == S_STEP) | (acc & (in_kind == KIND_READ) & idx_ok);
  assign ram_raddr = (state_r == S_STEP) ? ra_r : AW'(in_cell_index);

  hsd_ram #(
    .WIDTH (24),
    .DEPTH (GRID_MAX)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // the window is full once the right neighbour of an interior cell arrives
  assign upd_start = rv_r & (rd_a_r >= AW'(2));

  hsd_update u_upd (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (upd_start),
    .prev    (w0_r),
    .cur     (w1_r),
    .right   (ram_rdata),
    .coef    (coef_r),
    .res_vld (upd_vld),
    .res     (upd_res),
    .busy    (upd_busy)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_READ && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_READ && out_free) begin
      out_val_r <= err_r ? '0 : ram_rdata;
      out_err_r <= err_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cell_value  = out_val_r;
  assign out_index_error = out_err_r;

  // a result beat only ever follows a read
  a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_READ))
    else $error("output beat without a read");

  // the stencil unit only writes back during a step
  a_upd_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    upd_vld |-> (state_r == S_STEP || state_r == S_DRAIN))
    else $error("stencil write-back outside a step");

  // an out-of-range read carries a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_val_r == '0))
    else $error("index error with non-zero value");

  // an accepted read moves to the read state
  a_read_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_kind == KIND_READ) |=> (state_r == S_READ))
    else $error("read beat not followed by read state");

endmodule
